// File: hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions of the sha-256 message hash
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

	localparam int WordW = 32;
	localparam int TotalW = 61;
	localparam int QueueDepth = 2;
	localparam int QueueAw = 1;
	localparam logic [WordW-1:0] PadWord = 32'h8000_0000;

	// job handed from the front to the back engine
	typedef enum logic [1:0] {
		JOB_BLOCK = 2'd0,  // compress, keep chaining
		JOB_LAST  = 2'd1   // compress, then emit digest and restart
	} job_kind_t;

	typedef struct packed {
		job_kind_t            kind;
		logic [16*WordW-1:0] blk;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_ROUND = 2'd1,
		BK_ADD   = 2'd2,
		BK_EMIT  = 2'd3
	} back_state_t;

	typedef logic [WordW-1:0] word_t;

	localparam word_t InitHash [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

`default_nettype wire

// File: hdl/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// collects message words into blocks, appends padding and length
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [31:0]       in_word,
	input  wire logic [2:0]        in_nbytes,
	input  wire logic              in_last,
	output logic                   job_valid,
	input  wire logic              job_ready,
	output sha_pkg::job_t          job
);
	import sha_pkg::*;

	word_t                 blk_q [16];
	logic [TotalW-1:0]     total_q;
	// second closing block still to send (length, zero fill, pad word if needed)
	logic                  pend_q;
	logic [TotalW-1:0]     pend_total_q;

	logic [3:0]            idx;
	logic [2:0]            nb;
	logic                  acc;
	logic [TotalW-1:0]     new_total;
	logic [TotalW+2:0]     bits;
	word_t                 padded;
	word_t                 nblk [16];

	assign idx = total_q[5:2];
	assign nb = (in_nbytes > 3'd4) ? 3'd4 : in_nbytes;
	assign in_ready = !pend_q && job_ready;
	assign acc = in_valid && in_ready;

	always_comb begin
		unique case (nb)
			3'd0: padded = PadWord;
			3'd1: padded = {in_word[31:24], 24'h800000};
			3'd2: padded = {in_word[31:16], 16'h8000};
			3'd3: padded = {in_word[31:8], 8'h80};
			default: padded = in_word;
		endcase
	end

	assign new_total = in_last ? total_q + TotalW'(nb) : total_q + TotalW'(3'd4);

	always_comb begin
		job_valid = 1'b0;
		job.kind = JOB_BLOCK;
		for (int i = 0; i < 16; i++) nblk[i] = blk_q[i];
		bits = {pend_q ? pend_total_q : new_total, 3'b000};
		if (pend_q) begin
			nblk[14] = bits[63:32];
			nblk[15] = bits[31:0];
			job_valid = 1'b1;
			job.kind = JOB_LAST;
		end else if (in_valid && !in_last) begin
			nblk[idx] = in_word;
			job_valid = (idx == 4'd15);
		end else if (in_valid) begin
			job_valid = 1'b1;
			nblk[idx] = padded;
			if (nb == 3'd4) begin
				if (idx == 4'd15) begin
					// pad word opens a second block
				end else begin
					nblk[idx+4'd1] = PadWord;
				end
			end
			for (int i = 0; i < 16; i++) begin
				if (i > int'(idx) + ((nb == 3'd4) ? 1 : 0)) nblk[i] = '0;
			end
			if (nb == 3'd4 ? idx < 4'd13 : idx < 4'd14) begin
				nblk[14] = bits[63:32];
				nblk[15] = bits[31:0];
				job.kind = JOB_LAST;
			end
		end
		for (int i = 0; i < 16; i++) job.blk[(15-i)*WordW +: WordW] = nblk[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			pend_q <= 1'b0;
		end else if (pend_q) begin
			if (job_ready) pend_q <= 1'b0;
		end else if (acc) begin
			total_q <= in_last ? '0 : new_total;
			if (in_last && job.kind == JOB_BLOCK) begin
				pend_q <= 1'b1;
			end
		end
	end

	// second closing block: zero fill, pad word first when the first had no room
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < 16; i++) begin
				if (!(in_last && job.kind == JOB_BLOCK)) blk_q[i] <= nblk[i];
				else if (i == 0 && nb == 3'd4 && idx == 4'd15) blk_q[i] <= PadWord;
				else blk_q[i] <= '0;
			end
			pend_total_q <= new_total;
		end
	end

endmodule

`default_nettype wire

// File: hdl/sha_queue.sv
// ----------------------------------------------------------------------------
// sha_queue
// two-entry job queue between block assembly and compression
// ----------------------------------------------------------------------------
`default_nettype none

module sha_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire sha_pkg::job_t wr_job,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output sha_pkg::job_t      rd_job
);
	import sha_pkg::*;

	job_t               mem_q [QueueDepth];
	logic [QueueAw-1:0] wp_q, rp_q;
	logic [QueueAw:0]   cnt_q;
	logic               wr, rd;

	// a full queue still takes a beat in the cycle its head leaves
	assign wr_ready = (cnt_q != (QueueAw+1)'(QueueDepth)) || (rd_ready && rd_valid);
	assign rd_valid = (cnt_q != '0);
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QueueAw+1)'(wr) - (QueueAw+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end

endmodule

`default_nettype wire

// File: hdl/sha_back.sv
// ----------------------------------------------------------------------------
// sha_back
// 64-round compression, one round per cycle, and digest emission
// ----------------------------------------------------------------------------
`default_nettype none

module sha_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  wire sha_pkg::job_t job,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [31:0]        out_word,
	output logic [2:0]         out_num,
	output logic               out_last
);
	import sha_pkg::*;

	back_state_t state_q, state_d;
	word_t       h_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [5:0]  rnd_q;
	logic [2:0]  cnt_q;
	logic        last_q;
	word_t       t0, t1, wnew;

	assign t0 = v_q[7] + bsig1(v_q[4]) + (v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6])))
		+ RoundK[rnd_q] + w_q[0];
	assign t1 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1])));
	assign wnew = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (job_valid) state_d = BK_ROUND;
			BK_ROUND: if (rnd_q == 6'd63) state_d = BK_ADD;
			BK_ADD:   state_d = last_q ? BK_EMIT : BK_IDLE;
			BK_EMIT:  if (out_ready && cnt_q == 3'd7) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (state_q == BK_IDLE);
		out_valid = (state_q == BK_EMIT);
		out_word = h_q[cnt_q];
		out_num = cnt_q;
		out_last = (cnt_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			rnd_q <= '0;
			cnt_q <= '0;
			last_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
		end else begin
			state_q <= state_d;
			unique case (state_q)
				BK_IDLE: begin
					rnd_q <= '0;
					cnt_q <= '0;
					last_q <= (job.kind == JOB_LAST);
				end
				BK_ROUND: rnd_q <= rnd_q + 6'd1;
				BK_ADD: for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				BK_EMIT: if (out_ready) begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			for (int i = 0; i < 16; i++) w_q[i] <= job.blk[(15-i)*WordW +: WordW];
		end else if (state_q == BK_ROUND) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t0;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t0 + t1;
			// rolling 16-word message schedule
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
	end

endmodule

`default_nettype wire

// File: hdl/sha256_message_hash.sv
// ----------------------------------------------------------------------------
// sha256_message_hash
// sha-256 engine over a stream of big-endian 32-bit message words
// ----------------------------------------------------------------------------
// s_axis beats carry one message word; tlast marks the final word, whose
// valid byte count sits in tuser. the front packs words into 512-bit blocks,
// adds pad and bit length, and hands blocks through a two-entry queue to the
// compression engine, which runs one round per cycle.
// a block passes load, 64 rounds and chain add in the engine, which takes
// no new block before it is idle again; a final word adds one or two blocks,
// then eight digest beats on m_axis, word 0 first, tlast on the eighth.
// if the receiver stalls, the engine holds the digest and the queue fills,
// then s_axis_tready drops. reset returns the chaining words to the initial
// hash values and empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // message_word
	input  wire logic [2:0]  s_axis_tuser,   // valid_bytes
	input  wire logic        s_axis_tlast,   // final_word
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // hash_word, word_number, zero fill
	output logic             m_axis_tlast    // final_result
);
	import sha_pkg::*;

	logic  f_valid, f_ready, b_valid, b_ready;
	job_t  f_job, b_job;
	logic [31:0] o_word;
	logic [2:0]  o_num;

	sha_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_word(s_axis_tdata), .in_nbytes(s_axis_tuser), .in_last(s_axis_tlast),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	sha_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
	);

	sha_back u_back (
		.clk, .arst_n,
		.job_valid(b_valid), .job_ready(b_ready), .job(b_job),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_word(o_word), .out_num(o_num), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, o_num, o_word};

`ifndef SYNTHESIS
	a_last_num: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
		else $error("tlast out of step with word number");
	a_num_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
		else $error("digest words skipped");
`endif

endmodule

`default_nettype wire
